// File: hw/rtl/bgci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgci_pkg
// Shared types and fixed widths for the bilinear grid colour index unit.
// ----------------------------------------------------------------------------
package bgci_pkg;

	localparam int FRAC_BITS = 12;               // Q8.12 coordinates
	localparam int POS_W     = 20;
	localparam int CLAMP_W   = 7;
	localparam int VAL_W     = 32;               // Q16.16 samples
	localparam int LEVELS_W  = 9;
	localparam int COLOR_W   = 8;
	localparam int IDX_W     = 12;               // signed grid index, room for -1 .. 1024
	localparam int FX_W      = IDX_W + FRAC_BITS;
	localparam int FR_W      = 22;               // signed blend fraction
	localparam int IN_DATA_W = 88;
	localparam int CFG_IDX_W = 3;

	localparam logic [63:0] EPS_Q32 = 64'd429497; // 0.0001 in Q.32

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_LO    = 3'd0,
		REG_ROW_HI    = 3'd1,
		REG_COL_LO    = 3'd2,
		REG_COL_HI    = 3'd3,
		REG_VAL_LOW   = 3'd4,
		REG_VAL_SCALE = 3'd5,
		REG_LIN_MODE  = 3'd6,
		REG_LEVELS    = 3'd7
	} cfg_reg_t;

endpackage
`default_nettype wire

// File: hw/rtl/bilinear_grid_color_index_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_grid_color_index_unit
// Sample grid with bilinear or nearest lookup, mapped to a colour map level.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: row, col, value, row_pos,
//                                              col_pos; tuser: operation
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: color_index
//  cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
//  One transaction per clock sustained while m_axis_tready is high. The
//  pipeline is 27 register stages: 13 arithmetic stages, one stage per
//  4-bit digit of the 49-bit level in the modulo divider (13), and the
//  output register. Writes are committed at the second stage, in order
//  with queries. Each stage holds its item only while the stage after
//  it is full and stalled, so bubbles close up and the input keeps
//  flowing while a result waits. The grid has no clearing pass; reset
//  clears only control state.
// ----------------------------------------------------------------------------
module bilinear_grid_color_index_unit #(
	parameter int GRID_ROWS  = 64,
	parameter int GRID_COLS  = 64,
	parameter int MAX_LEVELS = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [6:0] grid_row, [13:7] grid_col, [45:14] grid_value,
	// [65:46] row_pos, [85:66] col_pos, [87:86] zero
	input  logic [bgci_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [0] operation
	input  logic [0:0]                         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [7:0] color_index
	output logic [bgci_pkg::COLOR_W-1:0]       m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bgci_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bgci_pkg::VAL_W-1:0]         cfg_data
);
	import bgci_pkg::*;

	// grid split into four banks by row/column parity, so the four
	// neighbours of a point always land in different banks
	localparam int HR         = (GRID_ROWS + 1) / 2;
	localparam int HC         = (GRID_COLS + 1) / 2;
	localparam int BANK_DEPTH = HR * HC;
	localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	localparam int TW   = FR_W + 33 - FRAC_BITS + 1;  // first blend result
	localparam int DTW  = TW + 1;
	localparam int PVW  = FR_W + DTW;
	localparam int VW   = 56;                         // blended value
	localparam int HW   = VW / 2;                     // multiplier split
	localparam int PPW  = HW + 16;
	localparam int LVL_W = 49;
	localparam int DIG  = 4;
	localparam int NK   = (LVL_W + DIG - 1) / DIG;
	localparam int LP   = NK * DIG;
	localparam int MW   = $clog2(MAX_LEVELS);
	localparam int CW   = (MW > COLOR_W) ? MW : COLOR_W;
	localparam int LCW  = ($clog2(MAX_LEVELS + 1) > LEVELS_W) ? $clog2(MAX_LEVELS + 1)
	                                                          : LEVELS_W;
	localparam int NS   = 14 + NK;

	// ---------------- configuration ----------------
	logic [CLAMP_W-1:0]  row_lo_q, row_hi_q, col_lo_q, col_hi_q;
	logic [VAL_W-1:0]    val_low_q, val_scale_q;
	logic                lin_q;
	logic [LEVELS_W-1:0] levels_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_lo_q    <= CLAMP_W'(1);
			row_hi_q    <= CLAMP_W'(64);
			col_lo_q    <= CLAMP_W'(1);
			col_hi_q    <= CLAMP_W'(64);
			val_low_q   <= '0;
			val_scale_q <= VAL_W'(65536);
			lin_q       <= 1'b1;
			levels_q    <= LEVELS_W'(256);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_LO:    row_lo_q    <= cfg_data[CLAMP_W-1:0];
				REG_ROW_HI:    row_hi_q    <= cfg_data[CLAMP_W-1:0];
				REG_COL_LO:    col_lo_q    <= cfg_data[CLAMP_W-1:0];
				REG_COL_HI:    col_hi_q    <= cfg_data[CLAMP_W-1:0];
				REG_VAL_LOW:   val_low_q   <= cfg_data;
				REG_VAL_SCALE: val_scale_q <= cfg_data;
				REG_LIN_MODE:  lin_q       <= cfg_data[0];
				REG_LEVELS:    levels_q    <= cfg_data[LEVELS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic [NS:1]   vld;
	logic [NS+1:1] en;

	always_comb begin
		en[NS+1] = m_axis_tready;
		for (int k = NS; k >= 1; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = vld[NS];

	// ---------------- stage 1: index, rounding and clamp ----------------
	function automatic logic signed [IDX_W-1:0] to_index(
		input logic [POS_W-1:0] pos, input logic [CLAMP_W-1:0] lo,
		input logic [CLAMP_W-1:0] hi, input logic lin);
		logic [POS_W:0]          rsum;
		logic signed [IDX_W-1:0] idx, los, his;
		rsum = {1'b0, pos} + (lin ? '0 : (POS_W+1)'(1 << (FRAC_BITS - 1)));
		idx  = $signed(IDX_W'(rsum >> FRAC_BITS));
		los  = $signed(IDX_W'(lo));
		his  = $signed(IDX_W'(hi)) - IDX_W'(1);
		if (idx < los) idx = los;
		if (idx > his) idx = his;   // high bound wins
		return idx;
	endfunction

	op_t                     op_s1;
	logic signed [IDX_W-1:0] il_s1, jl_s1;
	logic [POS_W-1:0]        rpos_s1, cpos_s1;
	logic [CLAMP_W-1:0]      wrow_s1, wcol_s1;
	logic [VAL_W-1:0]        wval_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s1   <= op_t'(s_axis_tuser[0]);
			il_s1   <= to_index(s_axis_tdata[65:46], row_lo_q, row_hi_q, lin_q);
			jl_s1   <= to_index(s_axis_tdata[85:66], col_lo_q, col_hi_q, lin_q);
			rpos_s1 <= s_axis_tdata[65:46];
			cpos_s1 <= s_axis_tdata[85:66];
			wrow_s1 <= s_axis_tdata[6:0];
			wcol_s1 <= s_axis_tdata[13:7];
			wval_s1 <= s_axis_tdata[45:14];
		end
	end

	// ---------------- stage 2: bank access ----------------
	function automatic logic [AW-1:0] bank_addr(input logic [IDX_W-1:0] r0,
		input logic [IDX_W-1:0] c0);
		logic [31:0] rh, ch;
		rh = 32'(r0[IDX_W-1:1]);
		ch = 32'(c0[IDX_W-1:1]);
		return AW'(rh + ch * 32'(HR));
	endfunction

	logic signed [IDX_W-1:0] ilm, jlm, rsel [2], csel [2];
	logic                    rok [2], cok [2];
	logic [AW-1:0]           raddr [4];
	logic [IDX_W-1:0]        wr0, wc0;
	logic                    wok, we;
	logic [1:0]              wbank;
	logic [AW-1:0]           waddr;
	logic signed [FX_W-1:0]  fi_w, fj_w;

	always_comb begin
		ilm = il_s1 - IDX_W'(1);
		jlm = jl_s1 - IDX_W'(1);
		for (int p = 0; p < 2; p++) begin
			rsel[p] = (ilm[0] == 1'(p)) ? il_s1 : il_s1 + IDX_W'(1);
			csel[p] = (jlm[0] == 1'(p)) ? jl_s1 : jl_s1 + IDX_W'(1);
			rok[p]  = (rsel[p] >= $signed(IDX_W'(1))) &&
			          (rsel[p] <= $signed(IDX_W'(GRID_ROWS)));
			cok[p]  = (csel[p] >= $signed(IDX_W'(1))) &&
			          (csel[p] <= $signed(IDX_W'(GRID_COLS)));
		end
		for (int b = 0; b < 4; b++) begin
			raddr[b] = bank_addr(rsel[b % 2] - IDX_W'(1), csel[b / 2] - IDX_W'(1));
		end
		wr0   = IDX_W'(wrow_s1) - IDX_W'(1);
		wc0   = IDX_W'(wcol_s1) - IDX_W'(1);
		wok   = (wrow_s1 != '0) && (IDX_W'(wrow_s1) <= IDX_W'(GRID_ROWS)) &&
		        (wcol_s1 != '0) && (IDX_W'(wcol_s1) <= IDX_W'(GRID_COLS));
		wbank = {wc0[0], wr0[0]};
		waddr = bank_addr(wr0, wc0);
		we    = en[2] && vld[1] && (op_s1 == OP_WRITE) && wok;
		fi_w  = $signed(FX_W'(rpos_s1)) - $signed({il_s1, FRAC_BITS'(0)});
		fj_w  = $signed(FX_W'(cpos_s1)) - $signed({jl_s1, FRAC_BITS'(0)});
	end

	logic [VAL_W-1:0]       rd_s2 [4];
	logic [3:0]             ok_s2;
	logic                   pi_s2, pj_s2, lin_s2;
	logic signed [FR_W-1:0] fi_s2, fj_s2;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [VAL_W-1:0] mem [0:BANK_DEPTH-1];
		always_ff @(posedge clk) begin
			if (we && (wbank == 2'(b))) mem[waddr] <= wval_s1;
			if (en[2]) rd_s2[b] <= mem[raddr[b]];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int b = 0; b < 4; b++) ok_s2[b] <= rok[b % 2] && cok[b / 2];
			pi_s2  <= ilm[0];
			pj_s2  <= jlm[0];
			lin_s2 <= lin_q;
			fi_s2  <= fi_w[FR_W-1:0];
			fj_s2  <= fj_w[FR_W-1:0];
		end
	end

	// ---------------- stage 3: neighbour select, differences ----------------
	logic [1:0]              b00, b01, b10, b11;
	logic signed [VAL_W-1:0] z00, z01, z10, z11;

	always_comb begin
		b00 = {pj_s2, pi_s2};
		b01 = {~pj_s2, pi_s2};
		b10 = {pj_s2, ~pi_s2};
		b11 = {~pj_s2, ~pi_s2};
		z00 = ok_s2[b00] ? $signed(rd_s2[b00]) : '0;
		z01 = ok_s2[b01] ? $signed(rd_s2[b01]) : '0;
		z10 = ok_s2[b10] ? $signed(rd_s2[b10]) : '0;
		z11 = ok_s2[b11] ? $signed(rd_s2[b11]) : '0;
	end

	logic signed [VAL_W-1:0] z00_s3, z10_s3;
	logic signed [VAL_W:0]   dtop_s3, dbot_s3;
	logic signed [FR_W-1:0]  fi_s3, fj_s3;
	logic                    lin_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			z00_s3  <= z00;
			z10_s3  <= z10;
			dtop_s3 <= (VAL_W+1)'(z01) - (VAL_W+1)'(z00);
			dbot_s3 <= (VAL_W+1)'(z11) - (VAL_W+1)'(z10);
			fi_s3   <= fi_s2;
			fj_s3   <= fj_s2;
			lin_s3  <= lin_s2;
		end
	end

	// ---------------- stage 4: column blend products ----------------
	logic signed [FR_W+VAL_W:0] ptop_s4, pbot_s4;
	logic signed [VAL_W-1:0]    z00_s4, z10_s4;
	logic signed [FR_W-1:0]     fi_s4;
	logic                       lin_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ptop_s4 <= fj_s3 * dtop_s3;
			pbot_s4 <= fj_s3 * dbot_s3;
			z00_s4  <= z00_s3;
			z10_s4  <= z10_s3;
			fi_s4   <= fi_s3;
			lin_s4  <= lin_s3;
		end
	end

	// ---------------- stage 5: column blend results ----------------
	// t = a + floor(f*(b-a)/4096), same as floor(((4096-f)a + fb)/4096)
	logic signed [TW-1:0]    tl_s5, th_s5;
	logic signed [VAL_W-1:0] z00_s5;
	logic signed [FR_W-1:0]  fi_s5;
	logic                    lin_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			tl_s5  <= TW'(z00_s4) + TW'(ptop_s4 >>> FRAC_BITS);
			th_s5  <= TW'(z10_s4) + TW'(pbot_s4 >>> FRAC_BITS);
			z00_s5 <= z00_s4;
			fi_s5  <= fi_s4;
			lin_s5 <= lin_s4;
		end
	end

	// ---------------- stage 6: row difference ----------------
	logic signed [DTW-1:0]   dt_s6;
	logic signed [TW-1:0]    tl_s6;
	logic signed [VAL_W-1:0] z00_s6;
	logic signed [FR_W-1:0]  fi_s6;
	logic                    lin_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			dt_s6  <= DTW'(th_s5) - DTW'(tl_s5);
			tl_s6  <= tl_s5;
			z00_s6 <= z00_s5;
			fi_s6  <= fi_s5;
			lin_s6 <= lin_s5;
		end
	end

	// ---------------- stage 7: row blend product ----------------
	logic signed [PVW-1:0]   pv_s7;
	logic signed [TW-1:0]    tl_s7;
	logic signed [VAL_W-1:0] z00_s7;
	logic                    lin_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			pv_s7  <= fi_s6 * dt_s6;
			tl_s7  <= tl_s6;
			z00_s7 <= z00_s6;
			lin_s7 <= lin_s6;
		end
	end

	// ---------------- stage 8: value ----------------
	logic signed [VW-1:0] v_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			v_s8 <= lin_s7 ? VW'(tl_s7) + VW'(pv_s7 >>> FRAC_BITS) : VW'(z00_s7);
		end
	end

	// ---------------- stage 9: offset from value_low ----------------
	logic signed [VW:0] d_w;
	logic [VW-1:0]      ud_s9;
	logic               one_s9;

	assign d_w = (VW+1)'(v_s8) - (VW+1)'($signed(val_low_q));

	always_ff @(posedge clk) begin
		if (en[9]) begin
			ud_s9  <= d_w[VW-1:0];
			one_s9 <= d_w[VW] || (d_w == '0);
		end
	end

	// ---------------- stage 10: partial products with the scale ----------------
	logic [PPW-1:0] p_hh_s10, p_lh_s10, p_hl_s10, p_ll_s10;
	logic           one_s10;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			p_hh_s10 <= PPW'(ud_s9[VW-1:HW]) * PPW'(val_scale_q[31:16]);
			p_lh_s10 <= PPW'(ud_s9[HW-1:0])  * PPW'(val_scale_q[31:16]);
			p_hl_s10 <= PPW'(ud_s9[VW-1:HW]) * PPW'(val_scale_q[15:0]);
			p_ll_s10 <= PPW'(ud_s9[HW-1:0])  * PPW'(val_scale_q[15:0]);
			one_s10  <= one_s9;
		end
	end

	// ---------------- stage 11: recombine, 64-bit wrap ----------------
	logic [63:0] a_s11, u2_s11;
	logic        one_s11;

	always_ff @(posedge clk) begin
		if (en[11]) begin
			a_s11   <= 64'({p_hh_s10, HW'(0)} + (PPW+HW)'(p_lh_s10));
			u2_s11  <= 64'({p_hl_s10, HW'(0)} + (PPW+HW)'(p_ll_s10));
			one_s11 <= one_s10;
		end
	end

	// ---------------- stage 12: low word and high part ----------------
	// low takes only the bottom 16 bits of a; the rest goes to the high part
	logic [63:0] low_s12;
	logic [47:0] ah_s12;
	logic        one_s12;

	always_ff @(posedge clk) begin
		if (en[12]) begin
			low_s12 <= {32'h0000_0000, a_s11[15:0], 16'h0000} + u2_s11;
			ah_s12  <= a_s11[63:16];
			one_s12 <= one_s11;
		end
	end

	// ---------------- stage 13: level with epsilon ----------------
	logic [LVL_W-1:0] lvl_s13;
	logic             one_s13;
	logic [63:0]      low_m;

	assign low_m = low_s12 - EPS_Q32;

	always_ff @(posedge clk) begin
		if (en[13]) begin
			if (low_s12 >= EPS_Q32) begin
				lvl_s13 <= LVL_W'(ah_s12) + LVL_W'(low_m[63:32]);
				one_s13 <= one_s12;
			end else begin
				lvl_s13 <= LVL_W'(ah_s12 - 48'd1);
				one_s13 <= one_s12 || (ah_s12 == '0);
			end
		end
	end

	// ---------------- stages 14..: level mod (levels-1), 4 bits a stage --------
	logic [LCW-1:0] lev_c;
	logic [MW-1:0]  mdiv;

	always_comb begin
		lev_c = LCW'(levels_q);
		if (lev_c < LCW'(2)) lev_c = LCW'(2);
		if (lev_c > LCW'(MAX_LEVELS)) lev_c = LCW'(MAX_LEVELS);
		mdiv = MW'(lev_c - LCW'(1));
	end

	logic [MW-1:0] rem_sn [NK];
	logic [LP-1:0] lv_sn [NK];
	logic          one_sn [NK];
	logic [MW-1:0] rem_nx [NK];
	logic [LP-1:0] lv_nx [NK];

	always_comb begin
		logic [MW:0]   t;
		logic [MW-1:0] r;
		logic [LP-1:0] lv;
		for (int j = 0; j < NK; j++) begin
			r  = (j == 0) ? '0 : rem_sn[(j == 0) ? 0 : j - 1];
			lv = (j == 0) ? LP'(lvl_s13) : lv_sn[(j == 0) ? 0 : j - 1];
			for (int s = 0; s < DIG; s++) begin
				t = {r, lv[LP-1]};
				if (t >= {1'b0, mdiv}) t = t - {1'b0, mdiv};
				r  = t[MW-1:0];
				lv = {lv[LP-2:0], 1'b0};
			end
			rem_nx[j] = r;
			lv_nx[j]  = lv;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NK; j++) begin
			if (en[14 + j]) begin
				rem_sn[j] <= rem_nx[j];
				lv_sn[j]  <= lv_nx[j];
				one_sn[j] <= (j == 0) ? one_s13 : one_sn[(j == 0) ? 0 : j - 1];
			end
		end
	end

	// ---------------- output register ----------------
	logic [CW-1:0] color_w;

	assign color_w = one_sn[NK-1] ? CW'(1) : CW'(rem_sn[NK-1]) + CW'(1);

	always_ff @(posedge clk) begin
		if (en[NS]) m_axis_tdata <= color_w[COLOR_W-1:0];
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (en[k]) begin
					if (k == 1)      vld[k] <= s_axis_tvalid;
					else if (k == 2) vld[k] <= vld[1] && (op_s1 == OP_QUERY);
					else             vld[k] <= vld[(k > 1) ? k - 1 : 1];
				end
			end
		end
	end

endmodule
`default_nettype wire
